// File: rtl/core/u2a_pkg.sv
// u2a_pkg: types, constants and the code point fold table shared by the
// UTF-8 to ASCII folding unit. No dependencies.
`timescale 1ns / 1ps

package u2a_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned CP_W    = 21;

   localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd80;
   localparam logic [CHAR_W-1:0] CHAR_DOT         = 7'h2e;
   localparam logic [CHAR_W-1:0] CHAR_SPACE       = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL         = 7'h00;

   // What the back end has to do with one result word.
   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,   // value[6:0] is the final character
      KIND_CODE = 2'd1,   // value is a decoded code point, still to fold
      KIND_EOL  = 2'd2    // end of line, length is the line total
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [CP_W-1:0]  value;
      logic [LEN_W-1:0] length;
   } result_type;

   // One queue entry: everything one input byte produced (one or two words).
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   // Most Latin-1 letters fold to their base letter, a few punctuation marks to
   // ASCII, anything else to '.'.
   function automatic logic [CHAR_W-1:0] fold_cp(input logic [CP_W-1:0] cp);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_DOT;
      priority if (cp >= 21'hc0 && cp <= 21'hc6) ch = 7'h41;
      else if (cp == 21'hc7)                          ch = 7'h43;
      else if (cp >= 21'hc8 && cp <= 21'hcb)          ch = 7'h45;
      else if (cp >= 21'hcc && cp <= 21'hcf)          ch = 7'h49;
      else if (cp == 21'hd1)                          ch = 7'h4e;
      else if ((cp >= 21'hd2 && cp <= 21'hd6) || cp == 21'hd8) ch = 7'h4f;
      else if (cp >= 21'hd9 && cp <= 21'hdc)          ch = 7'h55;
      else if (cp == 21'hdd)                          ch = 7'h59;
      else if (cp == 21'hdf)                          ch = 7'h73;
      else if (cp >= 21'he0 && cp <= 21'he6)          ch = 7'h61;
      else if (cp == 21'he7)                          ch = 7'h63;
      else if (cp >= 21'he8 && cp <= 21'heb)          ch = 7'h65;
      else if (cp >= 21'hec && cp <= 21'hef)          ch = 7'h69;
      else if (cp == 21'hf1)                          ch = 7'h6e;
      else if ((cp >= 21'hf2 && cp <= 21'hf6) || cp == 21'hf8) ch = 7'h6f;
      else if (cp >= 21'hf9 && cp <= 21'hfc)          ch = 7'h75;
      else if (cp == 21'hfd || cp == 21'hff)          ch = 7'h79;
      else if (cp == 21'ha0)                          ch = 7'h20;
      else if (cp == 21'h2018 || cp == 21'h2019)      ch = 7'h27;
      else if (cp == 21'h201c || cp == 21'h201d)      ch = 7'h22;
      else if (cp == 21'h2013 || cp == 21'h2014)      ch = 7'h2d;
      else if (cp == 21'h2026)                        ch = CHAR_DOT;
      else if (cp == 21'h2022)                        ch = 7'h2a;
      else                                            ch = CHAR_DOT;
      return ch;
   endfunction

endpackage

// File: rtl/core/utf8_to_ascii_folder_unit.sv
// utf8_to_ascii_folder_unit: top level of the UTF-8 to ASCII folding unit.
// Depends on u2a_pkg, u2a_front, u2a_queue and u2a_back.
//
// Usage:
//  - req_ channel: one raw text byte per word (tdata[7:0]). A zero byte
//    closes the line.
//  - rsp_ channel: one folded ASCII character per word, tdata[6:0] the
//    character and tdata[14:7] the running line length; tlast marks the
//    end-of-line word, which carries character 0 and the line total.
//  - csr_: write-only max_length (characters per line, reset 80). Write it
//    only while the unit is idle.
//  - One byte gives zero, one or two words (two when a truncated sequence
//    is flushed as '.' before the interrupting byte).
//  - Path: the decoder writes the queue when a byte is accepted, and the
//    fold loads the output register from the queue head when that register
//    is empty or its held word is taken.
//  - Throughput: one byte per cycle while the queue is not full; the back end
//    drains one word per cycle while not stalled, so a two-word byte's extra
//    word is absorbed by the queue between the decoder and the output stage.
//  - Reset: decoder state, queue and output valid clear; max_length
//    returns to 80. No clearing pass.
//  - Stall: while rsp_tready is low the output word holds, the queue fills
//    and req_tready drops once it is full.
`timescale 1ns / 1ps

module utf8_to_ascii_folder_unit
   import u2a_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [6:0] out_char, [14:7] line_length, [15] 0
   output logic        rsp_tlast,    // end_of_line
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data   // max_length
);

   entry_type         push_data, head;
   logic              push, full, pop, empty;
   logic [CHAR_W-1:0] out_char;
   logic [LEN_W-1:0]  line_length;

   // the front stalls only on a full queue
   assign req_tready = !full;

   u2a_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .text_byte   (req_tdata),
      .byte_take   (req_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data)
   );

   u2a_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (empty)
   );

   u2a_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_char    (out_char),
      .line_length (line_length),
      .end_of_line (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, line_length, out_char};

endmodule

// File: rtl/core/u2a_front.sv
// u2a_front: UTF-8 sequence decoder and line length tracking.
// Depends on u2a_pkg. Emits one queue entry per byte that produces output.
`timescale 1ns / 1ps

module u2a_front
   import u2a_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic              byte_take,    // byte accepted this cycle
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   output logic              push,
   output entry_type         push_data
);

   logic [BYTE_W-1:0] max_len_ff;
   logic [1:0]        pend_ff,  pend_in;
   logic [CP_W-1:0]   acc_ff,   acc_in;
   logic [LEN_W-1:0]  wc_ff,    wc_in;

   logic       is_cont;
   logic       dot_v, main_v;
   result_type dot_r, main_r;

   assign is_cont = (text_byte[7:6] == 2'b10);

   always_comb begin
      pend_in = pend_ff;
      acc_in  = acc_ff;
      wc_in   = wc_ff;
      dot_v   = 1'b0;
      main_v  = 1'b0;
      dot_r   = '{kind: KIND_CHAR, value: CP_W'(CHAR_DOT), length: '0};
      main_r  = '{kind: KIND_CHAR, value: '0, length: '0};

      if (pend_ff != 2'd0 && is_cont) begin
         // continuation absorbed even past the length limit
         acc_in  = {acc_ff[CP_W-7:0], text_byte[5:0]};
         pend_in = pend_ff - 2'd1;
         if (pend_in == 2'd0 && wc_in < max_len_ff) begin
            wc_in  = wc_in + 1'b1;
            main_v = 1'b1;
            main_r = '{kind: KIND_CODE, value: acc_in, length: wc_in};
         end
      end else begin
         if (pend_ff != 2'd0) begin
            // truncated sequence: '.' then the byte is decoded afresh
            pend_in = 2'd0;
            acc_in  = '0;
            if (wc_in < max_len_ff) begin
               wc_in        = wc_in + 1'b1;
               dot_v        = 1'b1;
               dot_r.length = wc_in;
            end
         end

         if (text_byte == '0) begin
            main_v  = 1'b1;
            main_r  = '{kind: KIND_EOL, value: '0, length: wc_in};
            wc_in   = '0;
            pend_in = 2'd0;
            acc_in  = '0;
         end else if (wc_in < max_len_ff) begin
            if (!text_byte[7]) begin
               wc_in  = wc_in + 1'b1;
               main_v = 1'b1;
               main_r = '{kind: KIND_CHAR,
                          value: CP_W'((text_byte < 8'h20) ? CHAR_SPACE
                                                            : text_byte[6:0]),
                          length: wc_in};
            end else if (text_byte[7:5] == 3'b110) begin
               acc_in  = CP_W'(text_byte[4:0]);
               pend_in = 2'd1;
            end else if (text_byte[7:4] == 4'b1110) begin
               acc_in  = CP_W'(text_byte[3:0]);
               pend_in = 2'd2;
            end else if (text_byte[7:3] == 5'b11110) begin
               acc_in  = CP_W'(text_byte[2:0]);
               pend_in = 2'd3;
            end else begin
               // stray continuation or invalid lead
               wc_in  = wc_in + 1'b1;
               main_v = 1'b1;
               main_r = '{kind: KIND_CHAR, value: CP_W'(CHAR_DOT), length: wc_in};
            end
         end
      end
   end

   always_comb begin
      push_data = '{two: 1'b0, first: main_r, second: main_r};
      if (dot_v) begin
         push_data.first = dot_r;
         push_data.two   = main_v;
      end
   end

   assign push = byte_take && byte_valid && (dot_v || main_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LENGTH_RESET;
         pend_ff    <= 2'd0;
         acc_ff     <= '0;
         wc_ff      <= '0;
      end else begin
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         if (byte_take && byte_valid) begin
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
            wc_ff   <= wc_in;
         end
      end
   end

endmodule

// File: rtl/core/u2a_queue.sv
// u2a_queue: small register FIFO of decoded entries between front and back.
// Depends on u2a_pkg for the entry type.
`timescale 1ns / 1ps

module u2a_queue
   import u2a_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// File: rtl/core/u2a_back.sv
// u2a_back: unpacks queue entries into single words, folds code points and
// holds the output register. Depends on u2a_pkg.
`timescale 1ns / 1ps

module u2a_back
   import u2a_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  entry_type         head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] out_char,
   output logic [LEN_W-1:0]  line_length,
   output logic              end_of_line
);

   logic              valid_ff, valid_in;
   logic              sel_ff,   sel_in;     // 1: second word of head is next
   logic [CHAR_W-1:0] char_ff,  char_in;
   logic [LEN_W-1:0]  len_ff,   len_in;
   logic              eol_ff,   eol_in;
   logic              load;
   result_type        cur;

   assign load = !valid_ff || rsp_tready;
   assign cur  = sel_ff ? head.second : head.first;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      char_in  = char_ff;
      len_in   = len_ff;
      eol_in   = eol_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            len_in = cur.length;
            eol_in = (cur.kind == KIND_EOL);
            unique case (cur.kind)
               KIND_CHAR: char_in = cur.value[CHAR_W-1:0];
               KIND_CODE: char_in = fold_cp(cur.value);
               KIND_EOL:  char_in = CHAR_NUL;
               default:   char_in = CHAR_DOT;
            endcase
            if (!sel_ff && head.two) begin
               sel_in = 1'b1;
            end else begin
               sel_in = 1'b0;
               pop    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      char_ff <= char_in;
      len_ff  <= len_in;
      eol_ff  <= eol_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign out_char    = char_ff;
   assign line_length = len_ff;
   assign end_of_line = eol_ff;

endmodule

// File: rtl/core/u2a_checker.sv
// u2a_checker: port-level assertions for utf8_to_ascii_folder_unit, bound
// to the top level. Depends on the top level's port list only.
`timescale 1ns / 1ps

module u2a_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // nothing left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // end-of-line word carries a zero character
   a_eol_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[6:0] == 7'd0))
      else $error("end-of-line word with nonzero character");

   // ordinary characters are 0x20 or above and counted from one
   a_char_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |->
         (rsp_tdata[6:0] >= 7'h20 && rsp_tdata[14:7] != 8'd0 && !rsp_tdata[15]))
      else $error("character word with control code or zero length");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response word changed");

endmodule

bind utf8_to_ascii_folder_unit u2a_checker u_u2a_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
